[rtl/htsed_pkg.sv]
// Shared types, character codes and entity lookup for the tag strip / entity decode block.
// No dependencies; imported by every module under rtl.
package htsed_pkg;

   localparam int JOB_BYTES  = 6;
   localparam int NAME_MAX   = 4;
   localparam int NAME_COUNT = 7;

   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_SPACE = 8'h20;

   // One queued unit of output work: the bytes caused by one input transfer.
   typedef struct packed {
      logic [JOB_BYTES-1:0][7:0] data;
      logic [2:0]                count;
      logic                      text_end;
   } job_type;

   typedef struct packed {
      logic       hit;
      logic [7:0] symbol;
   } match_type;

   // Letters packed lowest byte first.
   typedef struct packed {
      logic [31:0] letters;
      logic [2:0]  length;
      logic [7:0]  symbol;
   } entity_type;

   function automatic entity_type entity_entry(input logic [2:0] idx);
      entity_type e;
      unique case (idx)
         3'd0:    e = '{letters: 32'h7073626E, length: 3'd4, symbol: 8'h20};
         3'd1:    e = '{letters: 32'h00706D61, length: 3'd3, symbol: 8'h26};
         3'd2:    e = '{letters: 32'h746F7571, length: 3'd4, symbol: 8'h22};
         3'd3:    e = '{letters: 32'h0000746C, length: 3'd2, symbol: 8'h3C};
         3'd4:    e = '{letters: 32'h00007467, length: 3'd2, symbol: 8'h3E};
         3'd5:    e = '{letters: 32'h736F7061, length: 3'd4, symbol: 8'h27};
         3'd6:    e = '{letters: 32'h79706F63, length: 3'd4, symbol: 8'hA9};
         default: e = '0;
      endcase
      return e;
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return ((c >= 8'h41) && (c <= 8'h5A)) ? (c | 8'h20) : c;
   endfunction

   // Compare the stored name against every known entity, case folded.
   function automatic match_type match_name(input logic [NAME_MAX-1:0][7:0] name,
                                            input logic [2:0]               len);
      entity_type e;
      match_type  m;
      logic       same;
      m = '0;
      for (int k = NAME_COUNT - 1; k >= 0; k--) begin
         e    = entity_entry(3'(k));
         same = (e.length == len);
         for (int i = 0; i < NAME_MAX; i++) begin
            if ((3'(i) < len) && (to_lower(name[i]) != e.letters[8*i +: 8])) begin
               same = 1'b0;
            end
         end
         if (same) begin
            m.hit    = 1'b1;
            m.symbol = e.symbol;
         end
      end
      return m;
   endfunction

endpackage

[rtl/htsed_front.sv]
// Front end: scan state, entity name store, and build of one output job per transfer.
// Depends on htsed_pkg.
module htsed_front import htsed_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] in_byte,
   input  logic       end_of_text,
   output job_type    job,
   output logic       job_push
);

   localparam logic [1:0] MODE_TEXT = 2'd0;
   localparam logic [1:0] MODE_LT   = 2'd1;
   localparam logic [1:0] MODE_TAG  = 2'd2;
   localparam logic [1:0] MODE_NAME = 2'd3;

   logic [1:0]                mode_ff, mode_in;
   logic [2:0]                len_ff, len_in;
   logic [NAME_MAX-1:0][7:0]  name_ff, name_in;
   match_type                 hit;
   logic                      flush, amp_open, do_plain;
   logic [2:0]                flush_len, base, count;
   logic [1:0][7:0]           tail;
   logic [1:0]                tail_cnt;
   logic [JOB_BYTES-1:0][7:0] flush_bytes;

   assign hit = match_name(name_ff, len_ff);

   always_comb begin
      mode_in   = mode_ff;
      len_in    = len_ff;
      name_in   = name_ff;
      flush     = 1'b0;
      flush_len = '0;
      amp_open  = 1'b0;
      do_plain  = 1'b0;
      tail      = '0;
      tail_cnt  = '0;
      unique case (mode_ff)
         MODE_TEXT: begin
            do_plain = 1'b1;
         end
         MODE_LT: begin
            if (in_byte == CH_SPACE) begin
               tail[0]  = CH_LT;
               tail_cnt = 2'd1;
               mode_in  = MODE_TEXT;
               do_plain = 1'b1;
            end else if (in_byte == CH_GT) begin
               mode_in = MODE_TEXT;
            end else begin
               mode_in = MODE_TAG;
            end
         end
         MODE_TAG: begin
            if (in_byte == CH_GT) begin
               mode_in = MODE_TEXT;
            end
         end
         MODE_NAME: begin
            if (is_letter(in_byte) && (len_ff < 3'(NAME_MAX))) begin
               name_in[len_ff[1:0]] = in_byte;
               len_in               = len_ff + 3'd1;
            end else if ((in_byte == CH_SEMI) && hit.hit) begin
               tail[0]  = hit.symbol;
               tail_cnt = 2'd1;
               len_in   = '0;
               mode_in  = MODE_TEXT;
            end else begin
               flush     = 1'b1;
               flush_len = len_ff;
               len_in    = '0;
               mode_in   = MODE_TEXT;
               do_plain  = 1'b1;
            end
         end
      endcase
      if (do_plain) begin
         if (in_byte == CH_LT) begin
            mode_in = MODE_LT;
         end else if (in_byte == CH_AMP) begin
            mode_in  = MODE_NAME;
            len_in   = '0;
            amp_open = 1'b1;
         end else begin
            tail[tail_cnt[0]] = in_byte;
            tail_cnt          = tail_cnt + 2'd1;
         end
      end
      // End of text: close an open '<' or entity, then return to plain text.
      if (end_of_text) begin
         if (mode_in == MODE_LT) begin
            tail[tail_cnt[0]] = CH_LT;
            tail_cnt          = tail_cnt + 2'd1;
         end else if (mode_in == MODE_NAME) begin
            if (amp_open) begin
               tail[tail_cnt[0]] = CH_AMP;
               tail_cnt          = tail_cnt + 2'd1;
            end else begin
               flush     = 1'b1;
               flush_len = len_in;
            end
         end
         mode_in = MODE_TEXT;
         len_in  = '0;
      end
   end

   assign flush_bytes = {8'h00, name_in, CH_AMP};
   assign base        = flush ? (flush_len + 3'd1) : 3'd0;
   assign count       = base + {1'b0, tail_cnt};

   always_comb begin
      logic [2:0] pos;
      logic [2:0] off;
      job.data     = '0;
      job.count    = count;
      job.text_end = end_of_text;
      for (int i = 0; i < JOB_BYTES; i++) begin
         pos = 3'(i);
         off = pos - base;
         if (pos < base) begin
            job.data[i] = flush_bytes[i];
         end else if (off < 3'd2) begin
            job.data[i] = tail[off[0]];
         end
      end
   end

   assign job_push = accept && ((count != 3'd0) || end_of_text);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_TEXT;
         len_ff  <= '0;
      end else if (accept) begin
         mode_ff <= mode_in;
         len_ff  <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         name_ff <= name_in;
      end
   end

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= 3'(NAME_MAX))
      else $error("entity name length out of range");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      accept && end_of_text |=> (mode_ff == MODE_TEXT) && (len_ff == 3'd0))
      else $error("scan state not cleared after end of text");

endmodule

[rtl/htsed_queue.sv]
// Short job queue between front and back end.
// Depends on htsed_pkg for job_type.
module htsed_queue import htsed_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output job_type head,
   output logic    empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type          slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : (p + PTR_W'(1));
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= advance(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= advance(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("job queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("job queue underflow");

endmodule

[rtl/htsed_back.sv]
// Back end: serialize queued jobs into result transfers through an output register.
// Depends on htsed_pkg for job_type.
module htsed_back import htsed_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  job_type    head,
   input  logic       empty,
   output logic       pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic [1:0] rsp_tuser,
   output logic       rsp_tlast
);

   logic       valid_ff;
   logic [2:0] idx_ff, idx_in;
   logic [7:0] byte_ff;
   logic       byte_valid_ff, run_last_ff, text_end_ff;
   logic       load, take, run_last;
   logic [2:0] last_idx;

   assign load     = !valid_ff || rsp_tready;
   assign take     = load && !empty;
   assign last_idx = (head.count == 3'd0) ? 3'd0 : (head.count - 3'd1);
   assign run_last = (idx_ff == last_idx);
   assign pop      = take && run_last;
   assign idx_in   = take ? (run_last ? 3'd0 : (idx_ff + 3'd1)) : idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         if (load) begin
            valid_ff <= !empty;
         end
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff       <= head.data[idx_ff];
         byte_valid_ff <= (head.count != 3'd0);
         run_last_ff   <= run_last;
         text_end_ff   <= run_last && head.text_end;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tuser  = {run_last_ff, byte_valid_ff};
   assign rsp_tlast  = text_end_ff;

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      idx_ff < 3'(JOB_BYTES))
      else $error("result index out of range");

   a_bare_marker: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !byte_valid_ff |-> run_last_ff && text_end_ff)
      else $error("bare end marker not closing the text");

endmodule

[rtl/html_tag_strip_entity_decode_unit.sv]
// Top level of the HTML tag strip and entity decode block.
// Depends on htsed_pkg, htsed_front, htsed_queue and htsed_back.
//
//  channel   direction  handshake              payload
//  req_*     in         req_tvalid/req_tready  tdata = in_byte, tlast = end_of_text
//  rsp_*     out        rsp_tvalid/rsp_tready  tdata = out_byte,
//                                               tuser = {run_last, byte_valid},
//                                               tlast = text_end
//
// One input transfer is taken per cycle while the job queue has room; the front end
// classifies it and its scan state updates in that same cycle.
// The back end gives one result transfer per cycle while rsp is ready, so an input
// that causes k results (k is 0 to 6, mostly 0 or 1) holds the back end for k
// transfers; the queue soaks up these bursts. A first result passes through a queue
// slot and then the output register before it is valid on rsp.
// Reset (synchronous, active high) clears scan state, queue pointers and output valid.
// A stall on rsp holds the output register; input stalls only once the queue is full.
module html_tag_strip_entity_decode_unit import htsed_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   // input text bytes
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // end_of_text
   // cleaned text bytes
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [1:0] rsp_tuser,   // [0] byte_valid, [1] run_last
   output logic       rsp_tlast    // text_end
);

   job_type job, head;
   logic    job_push, full, empty, pop, accept;

   // Accept whenever the queue can hold the job this byte may produce.
   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   // Front: scan mode, entity letters, job build.
   htsed_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .in_byte     (req_tdata),
      .end_of_text (req_tlast),
      .job         (job),
      .job_push    (job_push)
   );

   // Decouple front and back so each can stall on its own.
   htsed_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (job),
      .full     (full),
      .pop      (pop),
      .head     (head),
      .empty    (empty)
   );

   // Back: drain each job one byte per transfer.
   htsed_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .empty      (empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   a_push_only_on_accept: assert property (@(posedge clock) disable iff (reset)
      job_push |-> accept)
      else $error("job pushed without an input transfer");

endmodule
